// File: hdl/ortq_pkg.sv
// ----------------------------------------------------------------------------
// ortq_pkg
// Shared types and codes for the ordered record table core.
// ----------------------------------------------------------------------------
package ortq_pkg;

   localparam int NAME_W   = 64;
   localparam int COORD_W  = 16;
   localparam int RADIUS_W = 34;

   // request codes
   localparam logic [2:0] OP_INSERT     = 3'd0;
   localparam logic [2:0] OP_FIND_NAME  = 3'd1;
   localparam logic [2:0] OP_FIND_COORD = 3'd2;
   localparam logic [2:0] OP_DEL_NAME   = 3'd3;
   localparam logic [2:0] OP_DEL_COORD  = 3'd4;
   localparam logic [2:0] OP_RANGE      = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   typedef struct packed {
      logic [2:0]          req_type;
      logic [NAME_W-1:0]   key_name;
      logic [COORD_W-1:0]  x_coord;
      logic [COORD_W-1:0]  y_coord;
      logic [RADIUS_W-1:0] radius_sq;
   } req_type_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [NAME_W-1:0]  rec_name;
      logic [COORD_W-1:0] rec_x;
      logic [COORD_W-1:0] rec_y;
      logic               last;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic               is_insert;
      logic               is_find;
      logic               by_name;
      logic               is_delete;
      logic               is_range;
      logic [NAME_W-1:0]  name;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [RADIUS_W-1:0] rsq;
   } cmd_type;

endpackage

// File: hdl/ordered_record_table_with_range_query_core.sv
// ----------------------------------------------------------------------------
// ordered_record_table_with_range_query_core
// Insertion-ordered record table with find, delete and range query.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel (valid/stall) as one struct; results
// leave on the rsp_ channel, one or more per request, the final one marked
// by last. A front stage classifies requests into a two-entry queue; the
// back stage walks the table through a memory with one read and one write
// port, visiting each entry in a read state and then a compare state. A
// delete then moves each later record down one place, and a range query
// emits each hit as it is found. The back stage takes no new command until
// the last result of the current one is in the output register.
// Reset empties the table at once; no clearing pass is needed, as entries
// beyond the fill count are never used. While rsp_stall is high the
// result holds, and the back stage waits once it has its next result
// ready; the queue keeps taking requests until it is full, then raises
// req_stall.
// ----------------------------------------------------------------------------
module ordered_record_table_with_range_query_core #(
   parameter int TABLE_DEPTH = 32,
   parameter int COORD_BITS  = 16,
   parameter int NAME_BYTES  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ortq_pkg::req_type_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ortq_pkg::rsp_type      rsp_data
);

   logic              cmd_valid, cmd_take;
   ortq_pkg::cmd_type cmd_data;

   ortq_front #(.COORD_BITS(COORD_BITS), .NAME_BYTES(NAME_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   ortq_back #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_BITS(COORD_BITS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

// File: hdl/ortq_front.sv
// ----------------------------------------------------------------------------
// ortq_front
// Accepts request transactions, masks fields and queues classified commands.
// ----------------------------------------------------------------------------
module ortq_front #(
   parameter int COORD_BITS = 16,
   parameter int NAME_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ortq_pkg::req_type_type req_data,
   output logic                  cmd_valid,
   input  logic                  cmd_take,
   output ortq_pkg::cmd_type     cmd_data
);

   localparam int QDEPTH = 2;

   ortq_pkg::cmd_type q_ff [QDEPTH];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   ortq_pkg::cmd_type cls;
   logic push, pop;

   // name mask and coordinate sign extension
   function automatic logic [ortq_pkg::COORD_W-1:0] sext(input logic [ortq_pkg::COORD_W-1:0] v);
      logic [ortq_pkg::COORD_W-1:0] r;
      r = v;
      for (int b = 0; b < ortq_pkg::COORD_W; b++) begin
         if (b >= COORD_BITS) r[b] = v[COORD_BITS-1];
      end
      return r;
   endfunction

   function automatic logic [ortq_pkg::NAME_W-1:0] nmask(input logic [ortq_pkg::NAME_W-1:0] v);
      logic [ortq_pkg::NAME_W-1:0] r;
      r = v;
      for (int b = 0; b < ortq_pkg::NAME_W; b++) begin
         if (b >= NAME_BYTES*8) r[b] = 1'b0;
      end
      return r;
   endfunction

   // classify the request
   always_comb begin
      cls.is_insert = (req_data.req_type == ortq_pkg::OP_INSERT);
      cls.is_find   = (req_data.req_type == ortq_pkg::OP_FIND_NAME) ||
                      (req_data.req_type == ortq_pkg::OP_FIND_COORD) ||
                      (req_data.req_type == ortq_pkg::OP_DEL_NAME) ||
                      (req_data.req_type == ortq_pkg::OP_DEL_COORD);
      cls.by_name   = (req_data.req_type == ortq_pkg::OP_FIND_NAME) ||
                      (req_data.req_type == ortq_pkg::OP_DEL_NAME);
      cls.is_delete = (req_data.req_type == ortq_pkg::OP_DEL_NAME) ||
                      (req_data.req_type == ortq_pkg::OP_DEL_COORD);
      cls.is_range  = (req_data.req_type == ortq_pkg::OP_RANGE);
      cls.name      = nmask(req_data.key_name);
      cls.x         = sext(req_data.x_coord);
      cls.y         = sext(req_data.y_coord);
      cls.rsq       = req_data.radius_sq;
   end

   assign req_stall = (cnt_ff == 2'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_valid && cmd_take;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   // hold queue entries
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cls;
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QDEPTH))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !pop) else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1)) else $error("count slip");

endmodule

// File: hdl/ortq_back.sv
// ----------------------------------------------------------------------------
// ortq_back
// Walks the record table one entry at a time, reading then comparing each, to carry out each command.
// ----------------------------------------------------------------------------
module ortq_back #(
   parameter int TABLE_DEPTH = 32,
   parameter int COORD_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  ortq_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ortq_pkg::rsp_type rsp_data
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int CBITS_USED = (COORD_BITS < ortq_pkg::COORD_W) ? COORD_BITS
                                                                : ortq_pkg::COORD_W;
   localparam logic [ortq_pkg::COORD_W-1:0] CMASK =
      {ortq_pkg::COORD_W{1'b1}} >> (ortq_pkg::COORD_W - CBITS_USED);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_CHECK, S_SHIFT_RD, S_SHIFT_WR, S_EMIT
   } state_type;

   logic [ortq_pkg::NAME_W-1:0]  name_mem [TABLE_DEPTH];
   logic [ortq_pkg::COORD_W-1:0] x_mem    [TABLE_DEPTH];
   logic [ortq_pkg::COORD_W-1:0] y_mem    [TABLE_DEPTH];

   state_type          state_ff, state_in;
   ortq_pkg::cmd_type  cmd_ff, cmd_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               done_ff, done_in;     // emit closes the command
   ortq_pkg::rsp_type  stage_ff, stage_in;   // next result waiting for the port
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [ortq_pkg::NAME_W-1:0]  wr_name;
   logic [ortq_pkg::COORD_W-1:0] wr_x, wr_y;
   logic [IW-1:0]      rd_addr;
   logic [ortq_pkg::NAME_W-1:0]  rd_name_ff;
   logic [ortq_pkg::COORD_W-1:0] rd_x_ff, rd_y_ff;
   ortq_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // distance terms
   logic signed [ortq_pkg::COORD_W:0] dx, dy;
   logic [2*ortq_pkg::COORD_W+1:0]    d2;
   logic hit;

   assign dx = $signed({rd_x_ff[ortq_pkg::COORD_W-1], rd_x_ff}) -
               $signed({cmd_ff.x[ortq_pkg::COORD_W-1], cmd_ff.x});
   assign dy = $signed({rd_y_ff[ortq_pkg::COORD_W-1], rd_y_ff}) -
               $signed({cmd_ff.y[ortq_pkg::COORD_W-1], cmd_ff.y});
   assign d2 = (2*ortq_pkg::COORD_W+2)'(dx * dx) + (2*ortq_pkg::COORD_W+2)'(dy * dy);

   always_comb begin
      if (cmd_ff.is_range)
         hit = (d2 <= cmd_ff.rsq);
      else if (cmd_ff.by_name)
         hit = (rd_name_ff == cmd_ff.name);
      else
         hit = (rd_x_ff == cmd_ff.x) && (rd_y_ff == cmd_ff.y);
   end

   assign rd_addr  = IW'(idx_ff);
   assign cmd_take = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // write port
   always_comb begin
      wr_en = 1'b0;
      wr_addr = IW'(idx_ff);
      wr_name = rd_name_ff;
      wr_x = rd_x_ff;
      wr_y = rd_y_ff;
      if (cmd_take && cmd_data.is_insert && (count_ff < CW'(TABLE_DEPTH))) begin
         wr_en = 1'b1;
         wr_addr = IW'(count_ff);
         wr_name = cmd_data.name;
         wr_x = cmd_data.x;
         wr_y = cmd_data.y;
      end else if (state_ff == S_SHIFT_WR) begin
         wr_en = 1'b1;
         wr_addr = IW'(idx_ff - CW'(1));
      end
   end

   // table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[wr_addr] <= wr_name;
         x_mem[wr_addr]    <= wr_x;
         y_mem[wr_addr]    <= wr_y;
      end
      rd_name_ff <= name_mem[rd_addr];
      rd_x_ff    <= x_mem[rd_addr];
      rd_y_ff    <= y_mem[rd_addr];
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      done_in      = done_ff;
      stage_in     = stage_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_data;
               idx_in = '0;
               done_in = 1'b1;
               stage_in = '0;
               stage_in.last = 1'b1;
               if (cmd_data.is_insert) begin
                  if (count_ff < CW'(TABLE_DEPTH)) begin
                     count_in = count_ff + CW'(1);
                     stage_in.status = ortq_pkg::ST_OK;
                  end else begin
                     stage_in.status = ortq_pkg::ST_FULL;
                  end
                  state_in = S_EMIT;
               end else if (cmd_data.is_find || cmd_data.is_range) begin
                  if (count_ff == '0) begin
                     stage_in.status = cmd_data.is_range ? ortq_pkg::ST_DONE
                                                         : ortq_pkg::ST_MISS;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  stage_in.status = ortq_pkg::ST_MISS;
                  state_in = S_EMIT;
               end
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (hit) begin
               // stage the matching record
               stage_in = '0;
               stage_in.status   = ortq_pkg::ST_OK;
               stage_in.rec_name = rd_name_ff;
               stage_in.rec_x    = rd_x_ff & CMASK;
               stage_in.rec_y    = rd_y_ff & CMASK;
               stage_in.last     = !cmd_ff.is_range;
               if (cmd_ff.is_range) begin
                  done_in = 1'b0;
                  state_in = S_EMIT;
               end else if (cmd_ff.is_delete) begin
                  idx_in = idx_ff + CW'(1);
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_EMIT;
               end
            end else if (idx_ff + CW'(1) < count_ff) begin
               idx_in = idx_ff + CW'(1);
               state_in = S_READ;
            end else begin
               stage_in = '0;
               stage_in.status = cmd_ff.is_range ? ortq_pkg::ST_DONE : ortq_pkg::ST_MISS;
               stage_in.last = 1'b1;
               state_in = S_EMIT;
            end
         end
         // move each later record down one place
         S_SHIFT_RD: begin
            if (idx_ff < count_ff) state_in = S_SHIFT_WR;
            else begin
               count_in = count_ff - CW'(1);
               state_in = S_EMIT;
            end
         end
         S_SHIFT_WR: begin
            idx_in = idx_ff + CW'(1);
            state_in = S_SHIFT_RD;
         end
         // hand the staged result to the output register once it is free
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = stage_ff;
               rsp_valid_in = 1'b1;
               if (done_ff) state_in = S_IDLE;
               else if (idx_ff + CW'(1) < count_ff) begin
                  idx_in = idx_ff + CW'(1);
                  done_in = 1'b1;
                  state_in = S_READ;
               end else begin
                  stage_in = '0;
                  stage_in.status = ortq_pkg::ST_DONE;
                  stage_in.last = 1'b1;
                  done_in = 1'b1;
                  state_in = S_EMIT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      stage_ff <= stage_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_WR) |-> (idx_ff != '0)) else $error("shift below head");

endmodule

// File: sim/tb_ordered_record_table_with_range_query_core.sv
// ----------------------------------------------------------------------------
// tb_ordered_record_table_with_range_query_core
// Self-checking bench: drives table requests, predicts every response from
// a local copy of the table and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_ordered_record_table_with_range_query_core;

   localparam int DEPTH = 32;
   // request codes with no operation behind them
   localparam logic [2:0] OP_BAD_LO = 3'd6;
   localparam logic [2:0] OP_BAD_HI = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   ortq_pkg::req_type_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   ortq_pkg::rsp_type      rsp_data;

   // local copy of the table
   logic [ortq_pkg::NAME_W-1:0]  tbl_name [DEPTH];
   logic [ortq_pkg::COORD_W-1:0] tbl_x    [DEPTH];
   logic [ortq_pkg::COORD_W-1:0] tbl_y    [DEPTH];
   int                           tbl_fill = 0;

   ortq_pkg::rsp_type expected_rsps [$];
   int                n_errors = 0;
   int                rsp_wait = 0;

   ordered_record_table_with_range_query_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic ortq_pkg::rsp_type mk_rsp(logic [1:0] st,
                                                logic [ortq_pkg::NAME_W-1:0] n,
                                                logic [ortq_pkg::COORD_W-1:0] x,
                                                logic [ortq_pkg::COORD_W-1:0] y,
                                                logic lst);
      ortq_pkg::rsp_type r;
      r.status = st; r.rec_name = n; r.rec_x = x; r.rec_y = y; r.last = lst;
      return r;
   endfunction

   // squared distance of one stored record from a centre (fits 34 bits)
   function automatic logic [63:0] dist_sq(logic [ortq_pkg::COORD_W-1:0] ax,
                                           logic [ortq_pkg::COORD_W-1:0] ay,
                                           logic [ortq_pkg::COORD_W-1:0] bx,
                                           logic [ortq_pkg::COORD_W-1:0] by);
      longint dx, dy;
      dx = longint'($signed(ax)) - longint'($signed(bx));
      dy = longint'($signed(ay)) - longint'($signed(by));
      return 64'(dx * dx + dy * dy);
   endfunction

   // advance the table copy by one request and queue its responses
   task automatic predict_table(ortq_pkg::req_type_type q);
      int idx;
      idx = -1;
      case (q.req_type)
         ortq_pkg::OP_INSERT: begin
            if (tbl_fill >= DEPTH) begin
               expected_rsps.push_back(mk_rsp(ortq_pkg::ST_FULL, '0, '0, '0, 1'b1));
            end else begin
               tbl_name[tbl_fill] = q.key_name;
               tbl_x[tbl_fill] = q.x_coord;
               tbl_y[tbl_fill] = q.y_coord;
               tbl_fill++;
               expected_rsps.push_back(mk_rsp(ortq_pkg::ST_OK, '0, '0, '0, 1'b1));
            end
         end
         ortq_pkg::OP_FIND_NAME, ortq_pkg::OP_FIND_COORD,
         ortq_pkg::OP_DEL_NAME, ortq_pkg::OP_DEL_COORD: begin
            for (int i = 0; i < tbl_fill && idx < 0; i++) begin
               if ((q.req_type == ortq_pkg::OP_FIND_NAME ||
                    q.req_type == ortq_pkg::OP_DEL_NAME) ?
                   tbl_name[i] == q.key_name :
                   (tbl_x[i] == q.x_coord && tbl_y[i] == q.y_coord))
                  idx = i;
            end
            if (idx < 0) begin
               expected_rsps.push_back(mk_rsp(ortq_pkg::ST_MISS, '0, '0, '0, 1'b1));
            end else begin
               expected_rsps.push_back(mk_rsp(ortq_pkg::ST_OK, tbl_name[idx], tbl_x[idx],
                                              tbl_y[idx], 1'b1));
               if (q.req_type == ortq_pkg::OP_DEL_NAME ||
                   q.req_type == ortq_pkg::OP_DEL_COORD) begin
                  for (int i = idx; i + 1 < tbl_fill; i++) begin
                     tbl_name[i] = tbl_name[i+1];
                     tbl_x[i] = tbl_x[i+1];
                     tbl_y[i] = tbl_y[i+1];
                  end
                  tbl_fill--;
               end
            end
         end
         ortq_pkg::OP_RANGE: begin
            for (int i = 0; i < tbl_fill; i++)
               if (dist_sq(tbl_x[i], tbl_y[i], q.x_coord, q.y_coord) <= 64'(q.radius_sq))
                  expected_rsps.push_back(mk_rsp(ortq_pkg::ST_OK, tbl_name[i], tbl_x[i],
                                                 tbl_y[i], 1'b0));
            expected_rsps.push_back(mk_rsp(ortq_pkg::ST_DONE, '0, '0, '0, 1'b1));
         end
         default: expected_rsps.push_back(mk_rsp(ortq_pkg::ST_MISS, '0, '0, '0, 1'b1));
      endcase
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      n_errors++;
   endtask

   // send one transaction after a random gap
   task automatic send_req(logic [2:0] op, logic [ortq_pkg::NAME_W-1:0] n,
                           logic [ortq_pkg::COORD_W-1:0] x,
                           logic [ortq_pkg::COORD_W-1:0] y,
                           logic [ortq_pkg::RADIUS_W-1:0] rsq);
      ortq_pkg::req_type_type q;
      int gap;
      q.req_type = op; q.key_name = n; q.x_coord = x; q.y_coord = y; q.radius_sq = rsq;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_table(q);
   endtask

   // hold off each response for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_wait = $urandom_range(0, 14);
         rsp_stall <= (rsp_wait != 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= (rsp_wait != 0);
      end
   end

   // compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      ortq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_data), '0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.rec_name !== want.rec_name)
               report_mismatch("rec_name", rsp_data.rec_name, want.rec_name);
            if (rsp_data.rec_x !== want.rec_x)
               report_mismatch("rec_x", 64'(rsp_data.rec_x), 64'(want.rec_x));
            if (rsp_data.rec_y !== want.rec_y)
               report_mismatch("rec_y", 64'(rsp_data.rec_y), 64'(want.rec_y));
            if (rsp_data.last !== want.last)
               report_mismatch("last", 64'(rsp_data.last), 64'(want.last));
         end
      end
   end

   function automatic logic [ortq_pkg::NAME_W-1:0] rand_name();
      return {$urandom, $urandom};
   endfunction

   // drop valid and wait for every expected response
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // extremes, every operation, head delete, misses, unknown codes
   task automatic test_directed();
      send_req(ortq_pkg::OP_RANGE, '0, '0, '0, '0);
      send_req(ortq_pkg::OP_FIND_NAME, 64'h1, '0, '0, '0);
      send_req(ortq_pkg::OP_DEL_COORD, '0, '0, '0, '0);
      send_req(ortq_pkg::OP_INSERT, '1, 16'h7fff, 16'h7fff, '0);
      send_req(ortq_pkg::OP_INSERT, '0, 16'h8000, 16'h8000, '0);
      send_req(ortq_pkg::OP_INSERT, 64'h0041_4243, 16'd5, -16'sd7, '0);
      send_req(ortq_pkg::OP_FIND_NAME, 64'h0041_4243, '0, '0, '0);
      send_req(ortq_pkg::OP_FIND_COORD, '0, 16'h8000, 16'h8000, '0);
      send_req(ortq_pkg::OP_FIND_COORD, '0, 16'd1, 16'd1, '0);
      send_req(ortq_pkg::OP_RANGE, '0, 16'h7fff, 16'h8000, 34'h3_ffff_ffff);
      send_req(ortq_pkg::OP_RANGE, '0, 16'h8000, 16'h8000, 34'd0);
      send_req(ortq_pkg::OP_RANGE, '0, 16'd0, 16'd0, 34'd74);
      send_req(OP_BAD_LO, '1, '1, '1, '1);
      send_req(OP_BAD_HI, '0, '0, '0, '0);
      send_req(ortq_pkg::OP_DEL_NAME, '1, '0, '0, '0);
      send_req(ortq_pkg::OP_DEL_NAME, '1, '0, '0, '0);
      send_req(ortq_pkg::OP_DEL_COORD, '0, 16'd5, -16'sd7, '0);
      send_req(ortq_pkg::OP_DEL_COORD, '0, 16'h8000, 16'h8000, '0);
   endtask

   // fill past capacity, then empty from the head
   task automatic test_full_table();
      wait_drained();
      for (int i = 0; i <= DEPTH; i++)
         send_req(ortq_pkg::OP_INSERT, 64'(i + 100), 16'(i), 16'(-i), '0);
      send_req(ortq_pkg::OP_RANGE, '0, '0, '0, 34'h3_ffff_ffff);
      for (int i = 0; i < DEPTH; i++)
         send_req(ortq_pkg::OP_DEL_NAME, 64'(i + 100), '0, '0, '0);
   endtask

   // random mix, names and points drawn from small pools so that hits occur
   task automatic test_random_mix();
      logic [2:0]                    op;
      logic [ortq_pkg::NAME_W-1:0]   n;
      logic [ortq_pkg::COORD_W-1:0]  x, y;
      logic [ortq_pkg::RADIUS_W-1:0] rsq;
      for (int k = 0; k < 70; k++) begin
         op = (tbl_fill < 6) ? ortq_pkg::OP_INSERT : 3'($urandom_range(0, 7));
         if ($urandom_range(0, 3) == 0) op = 3'($urandom_range(0, 7));
         n = ($urandom_range(0, 2) == 0) ? rand_name() : 64'($urandom_range(0, 7));
         x = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6) - 3);
         y = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6) - 3);
         rsq = ($urandom_range(0, 3) == 0) ? {2'($urandom), $urandom} :
               34'($urandom_range(0, 40));
         send_req(op, n, x, y, rsq);
         if (k == 35) wait_drained();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_random_mix();
      wait_drained();
      repeat (200) @(posedge clock);
      if (n_errors == 0)
         $display("tb_ordered_record_table_with_range_query_core: clean");
      else
         $display("tb_ordered_record_table_with_range_query_core: errors");
      $finish;
   end

   // hold a hard limit on run time
   initial begin
      #20000000;
      $display("tb_ordered_record_table_with_range_query_core: errors");
      $finish;
   end

endmodule

// File: files.f
hdl/ortq_pkg.sv
hdl/ortq_front.sv
hdl/ortq_back.sv
hdl/ordered_record_table_with_range_query_core.sv
sim/tb_ordered_record_table_with_range_query_core.sv
